>>> design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console with cursor and scroll.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int COPY_COUNT    = CELL_COUNT - SCREEN_WIDTH;

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } tcc_kind_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic scroll_step;
    logic fill_step;
    logic load_out;
  } tcc_cmd_t;

  typedef struct packed {
    tcc_kind_t kind;
    logic      need_scroll;
    logic      scroll_done;
    logic      fill_done;
  } tcc_status_t;

endpackage

>>> design/tcc_if.sv
// ----------------------------------------------------------------------------
// tcc channel interfaces
// Valid/ready channels for characters in, results out and attribute writes.
// ----------------------------------------------------------------------------
interface tcc_in_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] ch;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output kind, output ch, output cell_index, input ready);
  modport sink   (input valid, input kind, input ch, input cell_index, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [IDX_W-1:0]  cursor_index;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, output cursor_row, output cursor_col, output cursor_index,
                  output cell_data, input ready);
  modport sink   (input valid, input cursor_row, input cursor_col, input cursor_index,
                  input cell_data, output ready);
endinterface

interface tcc_cfg_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;

  modport source (output valid, output text_attribute, input ready);
  modport sink   (input valid, input text_attribute, output ready);
endinterface

>>> design/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: takes a transaction, runs its write, read, scroll or clear
// phase on the datapath, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcc_pkg::tcc_cmd_t    cmd,
  input  tcc_pkg::tcc_status_t stat
);
  import tcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.kind)
          KIND_WRITE: state_nxt = stat.need_scroll ? S_SCROLL : S_DONE;
          KIND_CLEAR: state_nxt = S_FILL;
          KIND_READ:  state_nxt = S_READ;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (stat.scroll_done) begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> design/tcc_datapath.sv
// ----------------------------------------------------------------------------
// tcc_datapath
// Screen store, cursor, attribute register, sweep counter and result
// registers.
// ----------------------------------------------------------------------------
module tcc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tcc_pkg::tcc_cmd_t                    cmd,
  output tcc_pkg::tcc_status_t                 stat,
  input  logic [tcc_pkg::KIND_W-1:0]           in_kind,
  input  logic [tcc_pkg::CHAR_W-1:0]           in_ch,
  input  logic [tcc_pkg::IDX_W-1:0]            in_cell_index,
  input  logic                                 cfg_we,
  input  logic [tcc_pkg::ATTR_W-1:0]           cfg_attr,
  output logic [tcc_pkg::ROW_W-1:0]            out_cursor_row,
  output logic [tcc_pkg::COL_W-1:0]            out_cursor_col,
  output logic [tcc_pkg::IDX_W-1:0]            out_cursor_index,
  output logic [tcc_pkg::CELL_W-1:0]           out_cell_data
);
  import tcc_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [IDX_W-1:0] IDX_WIDTH = IDX_W'(SCREEN_WIDTH);
  localparam logic [IDX_W-1:0] IDX_COPY  = IDX_W'(COPY_COUNT);
  localparam logic [IDX_W-1:0] IDX_CELLS = IDX_W'(CELL_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(CELL_COUNT - 1);

  logic [CELL_W-1:0] cells_r [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;

  tcc_kind_t         kind_r;
  logic [CHAR_W-1:0] ch_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ATTR_W-1:0] attr_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [IDX_W-1:0]  sweep_r;
  logic [IDX_W-1:0]  cur_idx;

  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CELL_W-1:0] out_data_r;

  logic              is_nl;
  logic              is_cr;
  logic              is_bs;
  logic              is_print;
  logic              row_last;
  logic              col_last;
  logic              in_range;
  logic [ROW_W-1:0]  row_down;
  logic [CELL_W-1:0] blank;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  assign cur_idx  = (IDX_W'(row_r) * IDX_WIDTH) + IDX_W'(col_r);
  assign is_nl    = (ch_r == CH_NEWLINE);
  assign is_cr    = (ch_r == CH_RETURN);
  assign is_bs    = (ch_r == CH_BACKSPACE);
  assign is_print = !is_nl && !is_cr && !is_bs;
  assign row_last = (row_r == ROW_LAST);
  assign col_last = (col_r == COL_LAST);
  assign in_range = (idx_r < IDX_CELLS);
  assign row_down = row_last ? row_r : row_r + ROW_W'(1);
  assign blank    = {attr_r, CH_SPACE};

  assign stat.kind        = kind_r;
  assign stat.need_scroll = row_last && (is_nl || (is_print && col_last));
  assign stat.scroll_done = (sweep_r == IDX_CELLS);
  assign stat.fill_done   = (sweep_r == IDX_LAST);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.exec) begin
      case (kind_r)
        KIND_WRITE: begin
          if (is_nl) begin
            col_nxt = '0;
            row_nxt = row_down;
          end else if (is_cr) begin
            col_nxt = '0;
          end else if (is_bs) begin
            if (col_r != '0) begin
              col_nxt = col_r - COL_W'(1);
            end else if (row_r != '0) begin
              row_nxt = row_r - ROW_W'(1);
              col_nxt = COL_LAST;
            end
          end else if (col_last) begin
            col_nxt = '0;
            row_nxt = row_down;
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
        KIND_CLEAR: begin
          row_nxt = '0;
          col_nxt = '0;
        end
        default: begin
          row_nxt = row_r;
        end
      endcase
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_r - IDX_W'(1);
    wr_data = blank;
    rd_en   = 1'b0;
    rd_addr = idx_r;
    if (cmd.exec) begin
      case (kind_r)
        KIND_WRITE: begin
          if (is_print) begin
            wr_en   = 1'b1;
            wr_addr = cur_idx;
            wr_data = {attr_r, ch_r};
          end else if (is_bs && (cur_idx != '0)) begin
            wr_en   = 1'b1;
            wr_addr = cur_idx - IDX_W'(1);
          end
        end
        KIND_READ: begin
          rd_en = in_range;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end
    if (cmd.scroll_step) begin
      rd_en   = (sweep_r < IDX_COPY);
      rd_addr = sweep_r + IDX_WIDTH;
      wr_en   = (sweep_r != '0);
      wr_data = (sweep_r <= IDX_COPY) ? rd_data_r : blank;
    end
    if (cmd.fill_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= cells_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      attr_r <= ATTR_RESET;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we) begin
        attr_r <= cfg_attr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= tcc_kind_t'(in_kind);
      ch_r   <= in_ch;
      idx_r  <= in_cell_index;
    end
    if (cmd.exec) begin
      sweep_r <= '0;
    end else if (cmd.scroll_step || cmd.fill_step) begin
      sweep_r <= sweep_r + IDX_W'(1);
    end
    if (cmd.load_out) begin
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_idx_r  <= cur_idx;
      out_data_r <= ((kind_r == KIND_READ) && in_range) ? rd_data_r : '0;
    end
  end

  assign out_cursor_row   = out_row_r;
  assign out_cursor_col   = out_col_r;
  assign out_cursor_index = out_idx_r;
  assign out_cell_data    = out_data_r;

endmodule

>>> design/text_console_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Character-cell terminal: screen store of 80 x 25 cells and a cursor.
//
// in_ch takes one transaction per item: kind 0 writes a character
// (newline, carriage return and backspace act as controls), kind 1 clears
// the screen and homes the cursor, kind 2 reads the cell at cell_index.
// out_ch returns one transaction per item with the cursor after the item
// and, for a read inside the screen, the cell contents (zero otherwise).
// cfg_ch writes the attribute byte; it is always ready.
// Each item is accepted in idle, executed, for a read also fetched from
// the store, and then loaded into the result register; the next item is
// accepted only after that load. A scroll and a clear each sweep the
// screen store one cell per cycle.
// in_ch.ready is high only while no item is in progress; a pending result
// does not block acceptance, but the next result waits while out_ch stalls.
// Reset homes the cursor, empties the result register and sets the
// attribute to 15. The store holds no defined contents until a clear.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top (
  input  logic      clk,
  input  logic      rst_n,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch,
  tcc_cfg_if.sink   cfg_ch
);
  import tcc_pkg::*;

  tcc_cmd_t    cmd;
  tcc_status_t stat;

  assign cfg_ch.ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tcc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_ch.kind),
    .in_ch            (in_ch.ch),
    .in_cell_index    (in_ch.cell_index),
    .cfg_we           (cfg_ch.valid),
    .cfg_attr         (cfg_ch.text_attribute),
    .out_cursor_row   (out_ch.cursor_row),
    .out_cursor_col   (out_ch.cursor_col),
    .out_cursor_index (out_ch.cursor_index),
    .out_cell_data    (out_ch.cell_data)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("block ready again straight after accepting a transaction");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.cursor_row < ROW_W'(SCREEN_HEIGHT)) &&
                      (out_ch.cursor_col < COL_W'(SCREEN_WIDTH))))
    else $error("reported cursor outside the screen");

  a_cursor_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cursor_index ==
      (IDX_W'(out_ch.cursor_row) * IDX_W'(SCREEN_WIDTH)) + IDX_W'(out_ch.cursor_col)))
    else $error("cursor index does not match row and column");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten while a result waits");
`endif

endmodule

>>> verif/text_console_cursor_scroll_checker.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_checker
// Watches the character, result and attribute channels of the text console.
// Keeps its own screen store, cursor and attribute, works out the cursor
// report for every accepted item and compares each returned transaction
// field by field with the oldest outstanding report.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_checker (
  input  logic clk,
  input  logic rst_n,
  tcc_in_if    in_ch,
  tcc_out_if   out_ch,
  tcc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [IDX_W-1:0]  cursor_index;
    logic [CELL_W-1:0] cell_data;
  } cursor_report_t;

  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  logic [ROW_W-1:0]  row_now;
  logic [COL_W-1:0]  col_now;
  logic [ATTR_W-1:0] attr_now;
  cursor_report_t    report_q [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_now, CH_SPACE};
  endfunction

  function automatic int cursor_cell();
    return int'(row_now) * SCREEN_WIDTH + int'(col_now);
  endfunction

  function automatic void advance_line();
    int i;
    col_now = '0;
    if (int'(row_now) == SCREEN_HEIGHT - 1) begin
      for (i = 0; i < COPY_COUNT; i++) screen_model[i] = screen_model[i + SCREEN_WIDTH];
      for (i = COPY_COUNT; i < CELL_COUNT; i++) screen_model[i] = blank_cell();
    end else begin
      row_now = row_now + 1'b1;
    end
  endfunction

  function automatic cursor_report_t predict_console(tcc_kind_t kind, logic [CHAR_W-1:0] ch,
                                                     logic [IDX_W-1:0] idx);
    cursor_report_t rep;
    int i;
    rep = '0;
    case (kind)
      KIND_WRITE: begin
        if (ch == CH_NEWLINE) begin
          advance_line();
        end else if (ch == CH_RETURN) begin
          col_now = '0;
        end else if (ch == CH_BACKSPACE) begin
          if (col_now != '0) begin
            col_now = col_now - 1'b1;
            screen_model[cursor_cell()] = blank_cell();
          end else if (row_now != '0) begin
            row_now = row_now - 1'b1;
            col_now = COL_W'(SCREEN_WIDTH - 1);
            screen_model[cursor_cell()] = blank_cell();
          end
        end else begin
          screen_model[cursor_cell()] = {attr_now, ch};
          if (int'(col_now) == SCREEN_WIDTH - 1) advance_line();
          else col_now = col_now + 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) screen_model[i] = blank_cell();
        row_now = '0;
        col_now = '0;
      end
      KIND_READ: begin
        if (int'(idx) < CELL_COUNT) rep.cell_data = screen_model[idx];
      end
      default: ;
    endcase
    rep.cursor_row   = row_now;
    rep.cursor_col   = col_now;
    rep.cursor_index = IDX_W'(cursor_cell());
    return rep;
  endfunction

  function automatic void check_field(string name, logic [CELL_W-1:0] want,
                                      logic [CELL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cursor_report_t want;
    int i;
    if (!rst_n) begin
      row_now  = '0;
      col_now  = '0;
      attr_now = ATTR_RESET;
      report_q.delete();
      for (i = 0; i < CELL_COUNT; i++) screen_model[i] = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual row %0d col %0d data 0x%0h",
                   $time, out_ch.cursor_row, out_ch.cursor_col, out_ch.cell_data);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(out_ch.cursor_row));
          check_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(out_ch.cursor_col));
          check_field("cursor_index", CELL_W'(want.cursor_index), CELL_W'(out_ch.cursor_index));
          check_field("cell_data", want.cell_data, out_ch.cell_data);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) attr_now = cfg_ch.text_attribute;
      if (in_ch.valid && in_ch.ready) begin
        report_q.push_back(predict_console(tcc_kind_t'(in_ch.kind), in_ch.ch, in_ch.cell_index));
      end
    end
    pending <= report_q.size();
  end

endmodule

>>> verif/text_console_cursor_scroll_top_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top_tb
// Drives the text console with a directed opening (controls at the screen
// edges, reads at the store limits, clear, unused kind) and then phases of
// random character runs, newline bursts, backspaces and reads under several
// attribute settings, with bursty input and a stalling result sink. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int PHASES          = 5;
  localparam int CYCLE_LIMIT     = 20_000_000;
  localparam int DRAIN_LIMIT     = 20_000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     sink_ready = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       burst_left = 0;
  int       cycle_count = 0;
  int       fail_count;
  int       pending;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();
  tcc_cfg_if cfg_ch ();

  assign out_ch.ready = sink_ready;

  text_console_cursor_scroll_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  text_console_cursor_scroll_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_cursor_scroll_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   sink_ready <= 1'b1;
      RX_COIN:   sink_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: sink_ready <= (rx_left % 3) != 0;
      default:   sink_ready <= (rx_left % 16) == 0;
    endcase
  end

  function automatic logic [CHAR_W-1:0] random_glyph();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom);
    while (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE) c = CHAR_W'($urandom);
    return c;
  endfunction

  task automatic send_item(tcc_kind_t kind, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.ch         <= ch;
    in_ch.cell_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] attr);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.text_attribute <= attr;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic random_traffic(int n_items);
    int done;
    int pick;
    int run;
    int k;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        run = $urandom_range(1, 24);
        for (k = 0; k < run; k++) send_item(KIND_WRITE, random_glyph(), IDX_W'($urandom));
        done += run;
      end else if (pick < 65) begin
        run = $urandom_range(1, 8);
        for (k = 0; k < run; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(KIND_READ, CHAR_W'($urandom), IDX_W'($urandom_range(CELL_COUNT, 2047)));
          end else begin
            send_item(KIND_READ, CHAR_W'($urandom), IDX_W'($urandom_range(0, CELL_COUNT - 1)));
            done++;
          end
        end
      end else if (pick < 73) begin
        run = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
        for (k = 0; k < run; k++) send_item(KIND_WRITE, CH_NEWLINE, IDX_W'($urandom));
        done += run;
      end else if (pick < 79) begin
        send_item(KIND_WRITE, CH_RETURN, IDX_W'($urandom));
        done++;
      end else if (pick < 87) begin
        run = $urandom_range(1, 12);
        for (k = 0; k < run; k++) send_item(KIND_WRITE, CH_BACKSPACE, IDX_W'($urandom));
        done += run;
      end else if (pick < 89) begin
        send_item(KIND_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
        done++;
      end else if (pick < 93) begin
        send_item(KIND_NONE, CHAR_W'($urandom), IDX_W'($urandom));
      end else begin
        send_item(KIND_WRITE, CHAR_W'($urandom), IDX_W'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    int phase;
    in_ch.valid           <= 1'b0;
    in_ch.kind            <= KIND_WRITE;
    in_ch.ch              <= '0;
    in_ch.cell_index      <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.text_attribute <= ATTR_RESET;
    rst_n                 <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // before the first clear, read back only the cell just written and indices beyond the store
    send_item(KIND_WRITE, 8'h41, '0);
    send_item(KIND_READ, '0, 11'd0);
    send_item(KIND_READ, '0, 11'd2047);
    send_item(KIND_READ, '0, IDX_W'(CELL_COUNT));
    send_item(KIND_NONE, 8'hFF, 11'h7FF);
    send_item(KIND_CLEAR, 8'h00, 11'h000);
    send_item(KIND_WRITE, CH_BACKSPACE, '0);
    send_item(KIND_WRITE, 8'h00, '0);
    send_item(KIND_WRITE, 8'hFF, '0);
    send_item(KIND_WRITE, CH_RETURN, '0);
    send_item(KIND_WRITE, CH_NEWLINE, '0);
    send_item(KIND_WRITE, CH_BACKSPACE, '0);
    send_item(KIND_WRITE, 8'h7E, '0);
    send_item(KIND_READ, '0, 11'd0);
    send_item(KIND_READ, '0, 11'd1);
    send_item(KIND_READ, '0, 11'd79);
    send_item(KIND_READ, '0, 11'd80);
    send_item(KIND_READ, '0, IDX_W'(CELL_COUNT - 1));
    send_item(KIND_WRITE, CH_BACKSPACE, '0);
    send_item(KIND_READ, '0, 11'd79);
    in_ch.valid <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       write_attribute(8'h00);
        1:       write_attribute(8'hFF);
        default: write_attribute(ATTR_W'($urandom));
      endcase
      random_traffic(ITEMS_PER_PHASE);
      in_ch.valid <= 1'b0;
    end

    settle();
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("text_console_cursor_scroll_top_tb: clean");
    end else begin
      $display("text_console_cursor_scroll_top_tb: errors");
    end
    $finish;
  end

endmodule
